// ----- rtl/seeded_no_repeat_random_picker_assert.svh -----
// assertion macros used by the picker checker
`ifndef SEEDED_NO_REPEAT_RANDOM_PICKER_ASSERT_SVH
`define SEEDED_NO_REPEAT_RANDOM_PICKER_ASSERT_SVH

// same-cycle implication, gated by reset
`define SRP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("picker check failed");

// next-cycle implication, gated by reset
`define SRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("picker check failed");

`endif

// ----- rtl/srp_pkg.sv -----
// types, constants and functions of the seeded random picker
package srp_pkg;

    localparam logic [31:0] FNV_BASIS  = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME  = 32'd16777619;
    localparam logic [31:0] ZERO_STEER = 32'h9e3779b9;
    localparam int unsigned INDEX_LIMIT = 256;

    typedef enum logic [1:0] {
        REQ_BEGIN = 2'd0,
        REQ_FOLD  = 2'd1,
        REQ_PICK  = 2'd2
    } req_kind_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] seed_byte;
    } srp_item_t;

    // one xorshift32 step with shifts 13, 17, 5
    function automatic logic [31:0] xorshift32(input logic [31:0] s);
        logic [31:0] t;
        begin
            t = s ^ (s << 13);
            t = t ^ (t >> 17);
            t = t ^ (t << 5);
            return t;
        end
    endfunction

endpackage

// ----- rtl/srp_req_if.sv -----
// request channel: valid, ready and one request word
interface srp_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] seed_byte;

    modport source (output valid, output req_type, output seed_byte, input ready);
    modport sink   (input valid, input req_type, input seed_byte, output ready);
endinterface

// ----- rtl/srp_res_if.sv -----
// result channel: valid, ready and one result word
interface srp_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] picked_index;
    logic       no_tracks;

    modport source (output valid, output picked_index, output no_tracks, input ready);
    modport sink   (input valid, input picked_index, input no_tracks, output ready);
endinterface

// ----- rtl/srp_in_stage.sv -----
// input register for request words
module srp_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    srp_req_if.sink             req,
    output logic                item_valid,
    output srp_pkg::srp_item_t  item,
    input  logic                item_take
);

    logic               valid_reg;
    logic               valid_next;
    srp_pkg::srp_item_t item_reg;
    logic               accept;

    assign req.ready  = !valid_reg || item_take;
    assign accept     = req.valid && req.ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (item_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.req_type  <= req.req_type;
            item_reg.seed_byte <= req.seed_byte;
        end
    end

endmodule

// ----- rtl/srp_core.sv -----
// generator state, pick logic and result register
module srp_core #(
    parameter int unsigned MAX_TRACKS = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  srp_pkg::srp_item_t  item,
    output logic                item_take,
    input  logic                cfg_we,
    input  logic [8:0]          cfg_wdata,
    srp_res_if.source           res
);

    localparam int unsigned CAP = (MAX_TRACKS < srp_pkg::INDEX_LIMIT) ?
                                  MAX_TRACKS : srp_pkg::INDEX_LIMIT;
    localparam logic [8:0] CAP_W = 9'(CAP);

    logic [8:0]  count_reg;
    logic [31:0] state_reg, state_next;
    logic        first_reg, first_next;
    logic [7:0]  last_reg, last_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_index_reg, out_index_next;
    logic        out_none_reg, out_none_next;

    logic        out_free;
    logic        is_pick;
    logic [8:0]  cnt;
    logic [31:0] seed_state;
    logic [31:0] step_state;
    logic [31:0] fold_state;
    logic [40:0] scaled;
    logic [8:0]  idx_raw;
    logic [8:0]  idx_inc;
    logic [8:0]  idx_pick;

    assign out_free  = !out_valid_reg || res.ready;
    assign is_pick   = (item.req_type == srp_pkg::REQ_PICK);
    assign item_take = item_valid && (!is_pick || out_free);

    // saturate the count so every index fits in 8 bits
    assign cnt = (count_reg > CAP_W) ? CAP_W : count_reg;

    assign fold_state = (state_reg ^ {24'd0, item.seed_byte}) * srp_pkg::FNV_PRIME;
    assign seed_state = (state_reg == 32'd0) ? srp_pkg::ZERO_STEER : state_reg;
    assign step_state = srp_pkg::xorshift32(seed_state);
    assign scaled     = 41'(step_state) * 41'(cnt);
    assign idx_raw    = scaled[40:32];
    assign idx_inc    = idx_raw + 9'd1;

    always_comb
    begin
        idx_pick = idx_raw;
        if (idx_raw == {1'b0, last_reg})
        begin
            idx_pick = (idx_inc >= cnt) ? 9'd0 : idx_inc;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        out_index_next = out_index_reg;
        out_none_next  = out_none_reg;
        out_valid_next = res.ready ? 1'b0 : out_valid_reg;
        if (item_take)
        begin
            case (item.req_type)
                srp_pkg::REQ_BEGIN:
                begin
                    state_next = srp_pkg::FNV_BASIS;
                    first_next = 1'b1;
                    last_next  = 8'd0;
                end
                srp_pkg::REQ_FOLD:
                begin
                    state_next = fold_state;
                end
                srp_pkg::REQ_PICK:
                begin
                    out_valid_next = 1'b1;
                    if (cnt == 9'd0)
                    begin
                        out_index_next = 8'd0;
                        out_none_next  = 1'b1;
                    end
                    else if (first_reg)
                    begin
                        first_next     = 1'b0;
                        last_next      = 8'd0;
                        out_index_next = 8'd0;
                        out_none_next  = 1'b0;
                    end
                    else
                    begin
                        state_next     = step_state;
                        last_next      = idx_pick[7:0];
                        out_index_next = idx_pick[7:0];
                        out_none_next  = 1'b0;
                    end
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= 9'd0;
            state_reg     <= srp_pkg::FNV_BASIS;
            first_reg     <= 1'b1;
            last_reg      <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
            state_reg     <= state_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_index_reg <= out_index_next;
        out_none_reg  <= out_none_next;
    end

    assign res.valid        = out_valid_reg;
    assign res.picked_index = out_index_reg;
    assign res.no_tracks    = out_none_reg;

endmodule

// ----- rtl/seeded_no_repeat_random_picker.sv -----
// top level of the seeded no-repeat random index picker
// a pick word passes the input register, then the result register; it waits while the result stalls
// throughput: one word per cycle while no pick waits on a stalled result; begin and fold words give no result
// the path that sets the rate is the xorshift step plus the 32x9 scaling multiply
// a stalled result holds in the output register; begin and fold words still pass, a pick waits
// reset: generator at the fnv offset basis, first-pick set, last index and count zero
module seeded_no_repeat_random_picker #(
    parameter int unsigned MAX_TRACKS = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    srp_req_if.sink    req,
    srp_res_if.source  res,
    input  logic       cfg_we,
    input  logic [8:0] cfg_wdata
);

    // word held between the input register and the pick logic
    logic               item_valid;
    srp_pkg::srp_item_t item;
    logic               item_take;

    // input register: frees itself whenever the core takes its word
    srp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    // state update and result register; fold and begin words never wait on the output
    srp_core #(
        .MAX_TRACKS (MAX_TRACKS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .res        (res)
    );

endmodule

// ----- rtl/srp_checker.sv -----
// port-level checks of the picker and the bind that attaches them
`include "seeded_no_repeat_random_picker_assert.svh"

module srp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic [1:0] req_type,
    input logic       res_valid,
    input logic       res_ready,
    input logic [7:0] picked_index,
    input logic       no_tracks
);

    logic pick_accept;

    assign pick_accept = req_valid && req_ready && (req_type == srp_pkg::REQ_PICK);

    // a stalled result word holds its value
    `SRP_ASSERT_NEXT(a_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(picked_index) && $stable(no_tracks))

    // a result word only goes away after it was taken
    `SRP_ASSERT_IMPLIES(a_drop, clk, rst_n, $fell(res_valid), $past(res_ready))

    // an empty pick always reports index zero
    `SRP_ASSERT_IMPLIES(a_none_zero, clk, rst_n, res_valid && no_tracks, picked_index == 8'd0)

    // an accepted pick reaches the output once the sink is ready
    `SRP_ASSERT_NEXT(a_pick_lat, clk, rst_n, pick_accept ##1 res_ready, res_valid)

endmodule

bind seeded_no_repeat_random_picker srp_checker u_srp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .req_type     (req.req_type),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .picked_index (res.picked_index),
    .no_tracks    (res.no_tracks)
);
